// ----- sv/pgd_pkg.sv -----
// shared types and constants of the process grid dimension chooser
package pgd_pkg;

   localparam int GRID_BITS   = 16;
   localparam int ACTIVE_BITS = 2;
   localparam int STATUS_BITS = 2;
   localparam int AXES        = 3;

   localparam logic [STATUS_BITS-1:0] STAT_OK        = 2'd0;
   localparam logic [STATUS_BITS-1:0] STAT_TOO_MANY  = 2'd1;
   localparam logic [STATUS_BITS-1:0] STAT_NO_AXIS   = 2'd2;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DIV,
      S_TM_NEXT,
      S_FACT,
      S_TRIAL,
      S_AX_NEXT,
      S_LIM,
      S_SCORE,
      S_APPLY,
      S_FINISH
   } state_type;

endpackage

// ----- sv/process_grid_dims_top.sv -----
// process grid dimension chooser: sequencer around one shared restoring divider
//
//  channel   ports                                   transfer
//  request   start, busy, req_rank_count, req_cells_*  start && !busy
//  result    rsp_valid, rsp_grid_*, rsp_active_axes,   rsp_valid (one cycle strobe)
//            rsp_status
//
//  the sequencer checks ranks against cells by three divisions, then finds each prime
//  factor of ranks by trial division; for each prime it divides the count of every
//  active axis by the prime and, where the axis can take it, by its grid to score it
//  reset is synchronous and returns the sequencer to idle
//  busy stays high from the transfer through the result strobe; no output stall
module process_grid_dims_top #(
   parameter int CELL_BITS = 20,
   parameter int RANK_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [RANK_BITS-1:0]               req_rank_count,
   input  logic [CELL_BITS-1:0]               req_cells_x,
   input  logic [CELL_BITS-1:0]               req_cells_y,
   input  logic [CELL_BITS-1:0]               req_cells_z,
   output logic                               rsp_valid,
   output logic [pgd_pkg::GRID_BITS-1:0]      rsp_grid_x,
   output logic [pgd_pkg::GRID_BITS-1:0]      rsp_grid_y,
   output logic [pgd_pkg::GRID_BITS-1:0]      rsp_grid_z,
   output logic [pgd_pkg::ACTIVE_BITS-1:0]    rsp_active_axes,
   output logic [pgd_pkg::STATUS_BITS-1:0]    rsp_status
);

   localparam int DIV_W  = (CELL_BITS > RANK_BITS) ? CELL_BITS : RANK_BITS;
   localparam int STEP_W = $clog2(DIV_W);

   pgd_pkg::state_type state_ff, state_in, ret_ff, ret_in;

   logic [CELL_BITS-1:0] cnt_ff [3];
   logic [CELL_BITS-1:0] cnt_in [3];
   logic [RANK_BITS-1:0] grid_ff [3];
   logic [RANK_BITS-1:0] grid_in [3];
   logic [1:0]           order_ff [3];
   logic [1:0]           order_in [3];
   logic [pgd_pkg::ACTIVE_BITS-1:0] active_ff, active_in;
   logic [pgd_pkg::STATUS_BITS-1:0] status_ff, status_in;
   logic [RANK_BITS-1:0] rest_ff, rest_in;
   logic [RANK_BITS-1:0] fac_ff, fac_in;
   logic [1:0]           tm_idx_ff, tm_idx_in;
   logic [1:0]           ax_idx_ff, ax_idx_in;
   logic                 have_ff, have_in;
   logic [1:0]           best_ff, best_in;
   logic [CELL_BITS-1:0] top_score_ff, top_score_in;

   // divider: quotient shifts in where the dividend shifts out
   logic [DIV_W-1:0]  dq_ff, dq_in;
   logic [DIV_W-1:0]  dr_ff, dr_in;
   logic [DIV_W-1:0]  dd_ff, dd_in;
   logic [STEP_W-1:0] dstep_ff, dstep_in;
   logic [DIV_W:0]    rem_sh;
   logic [DIV_W:0]    rem_diff;
   logic              rem_ge;
   logic              dstep_last;

   logic [CELL_BITS-1:0] raised [3];
   logic [1:0]           srt [3];
   logic [1:0]           tmp_idx;
   logic [pgd_pkg::ACTIVE_BITS-1:0] req_active;
   logic [RANK_BITS-1:0] rank_m1;
   logic [1:0]           tm_nxt;
   logic [1:0]           cur_ax;
   logic [2*RANK_BITS-1:0] prod;

   logic tm_last, trial_more, trial_past, ax_done, lim_skip, score_better, rest_gt1;

   // raise zero counts and sort axes, largest first, stable on ties
   always_comb begin
      raised[0] = (req_cells_x == '0) ? CELL_BITS'(1) : req_cells_x;
      raised[1] = (req_cells_y == '0) ? CELL_BITS'(1) : req_cells_y;
      raised[2] = (req_cells_z == '0) ? CELL_BITS'(1) : req_cells_z;
      tmp_idx = 2'd0;
      srt[0] = 2'd0;
      srt[1] = 2'd1;
      srt[2] = 2'd2;
      if (raised[srt[1]] > raised[srt[0]]) begin
         tmp_idx = srt[0]; srt[0] = srt[1]; srt[1] = tmp_idx;
      end
      if (raised[srt[2]] > raised[srt[1]]) begin
         tmp_idx = srt[1]; srt[1] = srt[2]; srt[2] = tmp_idx;
      end
      if (raised[srt[1]] > raised[srt[0]]) begin
         tmp_idx = srt[0]; srt[0] = srt[1]; srt[1] = tmp_idx;
      end
   end

   assign req_active = pgd_pkg::ACTIVE_BITS'({1'b0, req_cells_x > CELL_BITS'(1)}
                     + {1'b0, req_cells_y > CELL_BITS'(1)}
                     + {1'b0, req_cells_z > CELL_BITS'(1)});
   assign rank_m1 = (req_rank_count == '0) ? '0 : req_rank_count - RANK_BITS'(1);

   assign rem_sh     = {dr_ff, dq_ff[DIV_W-1]};
   assign rem_diff   = rem_sh - {1'b0, dd_ff};
   assign rem_ge     = ~rem_diff[DIV_W];
   assign dstep_last = (dstep_ff == STEP_W'(DIV_W - 1));

   assign tm_nxt  = tm_idx_ff + 2'd1;
   assign cur_ax  = (ax_idx_ff == 2'd2) ? order_ff[2] :
                    (ax_idx_ff == 2'd1) ? order_ff[1] : order_ff[0];
   assign prod    = (2*RANK_BITS)'(grid_ff[best_ff]) * (2*RANK_BITS)'(fac_ff);

   assign tm_last      = (tm_idx_ff == 2'd2);
   assign rest_gt1     = (rest_ff > RANK_BITS'(1));
   assign trial_past   = (DIV_W'(fac_ff) > dq_ff);
   assign trial_more   = !trial_past && (dr_ff != '0);
   assign ax_done      = (ax_idx_ff == active_ff);
   assign lim_skip     = (DIV_W'(grid_ff[cur_ax]) > dq_ff);
   assign score_better = !have_ff || (dq_ff[CELL_BITS-1:0] > top_score_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         pgd_pkg::S_IDLE:    if (start) state_in = pgd_pkg::S_DIV;
         pgd_pkg::S_DIV:     if (dstep_last) state_in = ret_ff;
         pgd_pkg::S_TM_NEXT: begin
            if (!tm_last) state_in = pgd_pkg::S_DIV;
            else if (dq_ff != '0) state_in = pgd_pkg::S_FINISH;
            else state_in = pgd_pkg::S_FACT;
         end
         pgd_pkg::S_FACT:    state_in = rest_gt1 ? pgd_pkg::S_DIV : pgd_pkg::S_FINISH;
         pgd_pkg::S_TRIAL:   state_in = trial_more ? pgd_pkg::S_DIV : pgd_pkg::S_AX_NEXT;
         pgd_pkg::S_AX_NEXT: begin
            if (!ax_done) state_in = pgd_pkg::S_DIV;
            else if (have_ff) state_in = pgd_pkg::S_APPLY;
            else state_in = pgd_pkg::S_FINISH;
         end
         pgd_pkg::S_LIM:     state_in = lim_skip ? pgd_pkg::S_AX_NEXT : pgd_pkg::S_DIV;
         pgd_pkg::S_SCORE:   state_in = pgd_pkg::S_AX_NEXT;
         pgd_pkg::S_APPLY:   state_in = pgd_pkg::S_FACT;
         pgd_pkg::S_FINISH:  state_in = pgd_pkg::S_IDLE;
         default:            state_in = pgd_pkg::S_IDLE;
      endcase
   end

   // datapath and divider loads
   always_comb begin
      cnt_in        = cnt_ff;
      grid_in       = grid_ff;
      order_in      = order_ff;
      active_in     = active_ff;
      status_in     = status_ff;
      rest_in       = rest_ff;
      fac_in        = fac_ff;
      tm_idx_in     = tm_idx_ff;
      ax_idx_in     = ax_idx_ff;
      have_in       = have_ff;
      best_in       = best_ff;
      top_score_in  = top_score_ff;
      ret_in        = ret_ff;
      dq_in         = dq_ff;
      dr_in         = dr_ff;
      dd_in         = dd_ff;
      dstep_in      = '0;
      case (state_ff)
         pgd_pkg::S_IDLE: begin
            if (start) begin
               cnt_in    = raised;
               grid_in   = '{default: RANK_BITS'(1)};
               order_in  = srt;
               active_in = req_active;
               status_in = pgd_pkg::STAT_OK;
               rest_in   = req_rank_count;
               tm_idx_in = 2'd0;
               // ranks > c0*c1*c2 iff ((ranks-1)/c0/c1/c2) != 0
               dq_in     = DIV_W'(rank_m1);
               dr_in     = '0;
               dd_in     = DIV_W'(raised[0]);
               ret_in    = pgd_pkg::S_TM_NEXT;
            end
         end
         pgd_pkg::S_DIV: begin
            dq_in    = {dq_ff[DIV_W-2:0], rem_ge};
            dr_in    = rem_ge ? rem_diff[DIV_W-1:0] : rem_sh[DIV_W-1:0];
            dstep_in = dstep_ff + STEP_W'(1);
         end
         pgd_pkg::S_TM_NEXT: begin
            if (!tm_last) begin
               tm_idx_in = tm_nxt;
               dq_in     = dq_ff;
               dr_in     = '0;
               dd_in     = DIV_W'(cnt_ff[tm_nxt]);
            end else if (dq_ff != '0) begin
               status_in = pgd_pkg::STAT_TOO_MANY;
            end
         end
         pgd_pkg::S_FACT: begin
            if (rest_gt1) begin
               fac_in = RANK_BITS'(2);
               dq_in  = DIV_W'(rest_ff);
               dr_in  = '0;
               dd_in  = DIV_W'(2);
               ret_in = pgd_pkg::S_TRIAL;
            end
         end
         pgd_pkg::S_TRIAL: begin
            if (trial_more) begin
               fac_in = fac_ff + RANK_BITS'(1);
               dq_in  = DIV_W'(rest_ff);
               dr_in  = '0;
               dd_in  = DIV_W'(fac_ff) + DIV_W'(1);
            end else begin
               // past the square root, rest itself is prime; else fac divides rest
               fac_in    = trial_past ? rest_ff : fac_ff;
               rest_in   = trial_past ? RANK_BITS'(1) : dq_ff[RANK_BITS-1:0];
               ax_idx_in = 2'd0;
               have_in   = 1'b0;
            end
         end
         pgd_pkg::S_AX_NEXT: begin
            if (!ax_done) begin
               dq_in  = DIV_W'(cnt_ff[cur_ax]);
               dr_in  = '0;
               dd_in  = DIV_W'(fac_ff);
               ret_in = pgd_pkg::S_LIM;
            end else if (!have_ff) begin
               status_in = pgd_pkg::STAT_NO_AXIS;
            end
         end
         pgd_pkg::S_LIM: begin
            if (lim_skip) begin
               ax_idx_in = ax_idx_ff + 2'd1;
            end else begin
               dq_in  = DIV_W'(cnt_ff[cur_ax]);
               dr_in  = '0;
               dd_in  = DIV_W'(grid_ff[cur_ax]);
               ret_in = pgd_pkg::S_SCORE;
            end
         end
         pgd_pkg::S_SCORE: begin
            if (score_better) begin
               have_in      = 1'b1;
               best_in      = cur_ax;
               top_score_in = dq_ff[CELL_BITS-1:0];
            end
            ax_idx_in = ax_idx_ff + 2'd1;
         end
         pgd_pkg::S_APPLY: begin
            grid_in[best_ff] = prod[RANK_BITS-1:0];
         end
         default: begin
         end
      endcase
   end

   // handshake outputs
   always_comb begin
      busy      = (state_ff != pgd_pkg::S_IDLE);
      rsp_valid = (state_ff == pgd_pkg::S_FINISH);
   end

   assign rsp_grid_x      = pgd_pkg::GRID_BITS'(grid_ff[0]);
   assign rsp_grid_y      = pgd_pkg::GRID_BITS'(grid_ff[1]);
   assign rsp_grid_z      = pgd_pkg::GRID_BITS'(grid_ff[2]);
   assign rsp_active_axes = active_ff;
   assign rsp_status      = status_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pgd_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      ret_ff        <= ret_in;
      cnt_ff        <= cnt_in;
      grid_ff       <= grid_in;
      order_ff      <= order_in;
      active_ff     <= active_in;
      status_ff     <= status_in;
      rest_ff       <= rest_in;
      fac_ff        <= fac_in;
      tm_idx_ff     <= tm_idx_in;
      ax_idx_ff     <= ax_idx_in;
      have_ff       <= have_in;
      best_ff       <= best_in;
      top_score_ff  <= top_score_in;
      dq_ff         <= dq_in;
      dr_ff         <= dr_in;
      dd_ff         <= dd_in;
      dstep_ff      <= dstep_in;
   end

   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff == pgd_pkg::S_DIV |-> dd_ff != '0)
      else $error("divider running with zero divisor");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy && !rsp_valid)
      else $error("transfer accepted but sequencer not running");

   a_too_many_unit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == pgd_pkg::STAT_TOO_MANY |->
         grid_ff[0] == RANK_BITS'(1) && grid_ff[1] == RANK_BITS'(1)
         && grid_ff[2] == RANK_BITS'(1))
      else $error("grid changed although ranks exceed cells");

   a_no_active_unit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == pgd_pkg::STAT_OK && rsp_active_axes == '0 |->
         grid_ff[0] == RANK_BITS'(1) && grid_ff[1] == RANK_BITS'(1)
         && grid_ff[2] == RANK_BITS'(1))
      else $error("factor placed on an inactive axis");

   a_apply_has_axis: assert property (@(posedge clock) disable iff (reset)
      state_ff == pgd_pkg::S_APPLY |-> have_ff && best_ff != 2'd3)
      else $error("factor applied without a chosen axis");

endmodule

// ----- test/process_grid_dims_top_tb.sv -----
// self-checking bench for the process grid dimension chooser: directed table, then random items
module process_grid_dims_top_tb;

   localparam int CELL_BITS = 20;
   localparam int RANK_BITS = 16;
   localparam logic [CELL_BITS-1:0] CELL_MAX = '1;
   localparam logic [RANK_BITS-1:0] RANK_MAX = '1;
   localparam int RANDOM_ITEMS = 1080;
   localparam int DRAIN_CYCLES = 200;

   typedef struct packed {
      logic [pgd_pkg::GRID_BITS-1:0]   gx;
      logic [pgd_pkg::GRID_BITS-1:0]   gy;
      logic [pgd_pkg::GRID_BITS-1:0]   gz;
      logic [pgd_pkg::ACTIVE_BITS-1:0] act;
      logic [pgd_pkg::STATUS_BITS-1:0] st;
   } grid_choice_type;

   typedef struct packed {
      logic [RANK_BITS-1:0] ranks;
      logic [CELL_BITS-1:0] cx;
      logic [CELL_BITS-1:0] cy;
      logic [CELL_BITS-1:0] cz;
      logic                 typed;
      grid_choice_type      want;
   } dims_row_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   start = 1'b0;
   logic                   busy;
   logic [RANK_BITS-1:0]   req_rank_count = '0;
   logic [CELL_BITS-1:0]   req_cells_x = '0;
   logic [CELL_BITS-1:0]   req_cells_y = '0;
   logic [CELL_BITS-1:0]   req_cells_z = '0;
   logic                   rsp_valid;
   logic [pgd_pkg::GRID_BITS-1:0]   rsp_grid_x;
   logic [pgd_pkg::GRID_BITS-1:0]   rsp_grid_y;
   logic [pgd_pkg::GRID_BITS-1:0]   rsp_grid_z;
   logic [pgd_pkg::ACTIVE_BITS-1:0] rsp_active_axes;
   logic [pgd_pkg::STATUS_BITS-1:0] rsp_status;

   grid_choice_type pending_choices[$];
   dims_row_type    dims_rows[$];
   int              errors = 0;
   bit              no_gap_run = 1'b0;

   process_grid_dims_top #(
      .CELL_BITS(CELL_BITS),
      .RANK_BITS(RANK_BITS)
   ) uut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_rank_count(req_rank_count),
      .req_cells_x(req_cells_x),
      .req_cells_y(req_cells_y),
      .req_cells_z(req_cells_z),
      .rsp_valid(rsp_valid),
      .rsp_grid_x(rsp_grid_x),
      .rsp_grid_y(rsp_grid_y),
      .rsp_grid_z(rsp_grid_z),
      .rsp_active_axes(rsp_active_axes),
      .rsp_status(rsp_status)
   );

   always #10 clock = ~clock;

   function automatic grid_choice_type choose_grid(input logic [RANK_BITS-1:0] ranks,
                                                   input logic [CELL_BITS-1:0] cx,
                                                   input logic [CELL_BITS-1:0] cy,
                                                   input logic [CELL_BITS-1:0] cz);
      longint unsigned cnt[3];
      longint unsigned grid[3];
      logic [CELL_BITS-1:0] raw[3];
      int order[3];
      int act;
      int best;
      int ax;
      int tmp;
      int i;
      longint unsigned rest;
      longint unsigned f;
      longint unsigned score;
      longint unsigned top_score;
      bit have;
      logic [pgd_pkg::STATUS_BITS-1:0] st;
      grid_choice_type res;
      raw[0] = cx;
      raw[1] = cy;
      raw[2] = cz;
      act = 0;
      st = pgd_pkg::STAT_OK;
      for (i = 0; i < pgd_pkg::AXES; i++) begin
         if (raw[i] > 1) act++;
         cnt[i] = (raw[i] < 1) ? 64'd1 : 64'(raw[i]);
         grid[i] = 64'd1;
         order[i] = i;
      end
      // 64 bits hold the full product of three 20-bit counts
      if (64'(ranks) > cnt[0] * cnt[1] * cnt[2]) st = pgd_pkg::STAT_TOO_MANY;
      // stable descending order of the axes by count
      if (cnt[order[1]] > cnt[order[0]]) begin
         tmp = order[0]; order[0] = order[1]; order[1] = tmp;
      end
      if (cnt[order[2]] > cnt[order[1]]) begin
         tmp = order[1]; order[1] = order[2]; order[2] = tmp;
      end
      if (cnt[order[1]] > cnt[order[0]]) begin
         tmp = order[0]; order[0] = order[1]; order[1] = tmp;
      end
      if (st == pgd_pkg::STAT_OK) begin
         rest = 64'(ranks);
         while (rest > 1) begin
            f = 64'd2;
            while (f <= rest / f && rest % f != 0) f++;
            if (f > rest / f) f = rest;
            have = 1'b0;
            best = 0;
            top_score = 64'd0;
            for (i = 0; i < act; i++) begin
               ax = order[i];
               if (grid[ax] > cnt[ax] / f) continue;
               score = cnt[ax] / grid[ax];
               if (!have || score > top_score) begin
                  have = 1'b1;
                  best = ax;
                  top_score = score;
               end
            end
            if (!have) begin
               st = pgd_pkg::STAT_NO_AXIS;
               break;
            end
            grid[best] = grid[best] * f;
            rest = rest / f;
         end
      end
      res.gx = grid[0][pgd_pkg::GRID_BITS-1:0];
      res.gy = grid[1][pgd_pkg::GRID_BITS-1:0];
      res.gz = grid[2][pgd_pkg::GRID_BITS-1:0];
      res.act = act[pgd_pkg::ACTIVE_BITS-1:0];
      res.st = st;
      return res;
   endfunction

   function automatic logic [CELL_BITS-1:0] draw_cells();
      case ($urandom_range(0, 3))
         0: return CELL_BITS'($urandom_range(0, 2));
         1, 2: return CELL_BITS'($urandom_range(1, 64));
         default: return CELL_BITS'($urandom_range(0, 2**CELL_BITS - 1));
      endcase
   endfunction

   task automatic add_row(input int ranks,
                          input int cx,
                          input int cy,
                          input int cz,
                          input int typed,
                          input int gx,
                          input int gy,
                          input int gz,
                          input int act,
                          input int st);
      dims_row_type r;
      r.ranks = RANK_BITS'(ranks);
      r.cx = CELL_BITS'(cx);
      r.cy = CELL_BITS'(cy);
      r.cz = CELL_BITS'(cz);
      r.typed = (typed != 0);
      r.want.gx = pgd_pkg::GRID_BITS'(gx);
      r.want.gy = pgd_pkg::GRID_BITS'(gy);
      r.want.gz = pgd_pkg::GRID_BITS'(gz);
      r.want.act = pgd_pkg::ACTIVE_BITS'(act);
      r.want.st = pgd_pkg::STATUS_BITS'(st);
      dims_rows.push_back(r);
   endtask

   task automatic send_item(input logic [RANK_BITS-1:0] ranks,
                            input logic [CELL_BITS-1:0] cx,
                            input logic [CELL_BITS-1:0] cy,
                            input logic [CELL_BITS-1:0] cz,
                            input logic typed,
                            input grid_choice_type want);
      int gap;
      if ($urandom_range(0, 39) == 0) no_gap_run = !no_gap_run;
      gap = no_gap_run ? 0 : $urandom_range(0, 14);
      // with no gap start stays high from the previous transfer
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_rank_count <= ranks;
      req_cells_x <= cx;
      req_cells_y <= cy;
      req_cells_z <= cz;
      do @(posedge clock); while (busy !== 1'b0);
      pending_choices.push_back(typed ? want : choose_grid(ranks, cx, cy, cz));
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         errors++;
         $display("%0t: %s expected %0d got %0d", $time, name, want, got);
      end
   endtask

   // results are stable through the strobe cycle, so sample mid-cycle
   always @(negedge clock) begin : result_check
      grid_choice_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (pending_choices.size() == 0) begin
            errors++;
            $display("%0t: result with no transfer waiting, expected none got %0d x %0d x %0d",
                     $time, rsp_grid_x, rsp_grid_y, rsp_grid_z);
         end else begin
            want = pending_choices.pop_front();
            check_field("grid_x", 32'(want.gx), 32'(rsp_grid_x));
            check_field("grid_y", 32'(want.gy), 32'(rsp_grid_y));
            check_field("grid_z", 32'(want.gz), 32'(rsp_grid_z));
            check_field("active_axes", 32'(want.act), 32'(rsp_active_axes));
            check_field("status", 32'(want.st), 32'(rsp_status));
         end
      end
   end

   initial begin
      #1_000_000_000;
      $display("FAILURE");
      $finish;
   end

   initial begin : stimulus
      int m;
      int smooth;
      int f;
      logic [RANK_BITS-1:0] ranks;
      logic [CELL_BITS-1:0] cx;
      logic [CELL_BITS-1:0] cy;
      logic [CELL_BITS-1:0] cz;
      grid_choice_type none;

      none = '0;
      //       ranks      cells x    cells y    cells z    typed  gx  gy     gz act status
      add_row(1,         1,         1,         1,         1,     1,  1,     1, 0, pgd_pkg::STAT_OK);
      add_row(0,         0,         0,         0,         1,     1,  1,     1, 0, pgd_pkg::STAT_OK);
      add_row(2,         0,         0,         0,         1,     1,  1,     1, 0,
              pgd_pkg::STAT_TOO_MANY);
      add_row(RANK_MAX,  0,         0,         0,         1,     1,  1,     1, 0,
              pgd_pkg::STAT_TOO_MANY);
      add_row(1,         CELL_MAX,  CELL_MAX,  CELL_MAX,  1,     1,  1,     1, 3, pgd_pkg::STAT_OK);
      add_row(7,         2,         2,         2,         1,     1,  1,     1, 3,
              pgd_pkg::STAT_NO_AXIS);
      add_row(8,         3,         3,         1,         1,     2,  2,     1, 2,
              pgd_pkg::STAT_NO_AXIS);
      add_row(8,         2,         2,         2,         1,     2,  2,     2, 3, pgd_pkg::STAT_OK);
      add_row(6,         1,         1,         6,         1,     1,  1,     6, 1, pgd_pkg::STAT_OK);
      add_row(RANK_MAX,  1,         65535,     1,         1,     1,  65535, 1, 1, pgd_pkg::STAT_OK);
      add_row(RANK_MAX,  1,         65534,     1,         1,     1,  1,     1, 1,
              pgd_pkg::STAT_TOO_MANY);
      add_row(3,         2,         1,         1,         1,     1,  1,     1, 1,
              pgd_pkg::STAT_TOO_MANY);
      add_row(2,         1,         2,         1,         1,     1,  2,     1, 1, pgd_pkg::STAT_OK);
      add_row(RANK_MAX,  CELL_MAX,  CELL_MAX,  CELL_MAX,  0,     0,  0,     0, 0, pgd_pkg::STAT_OK);
      add_row(65521,     CELL_MAX,  CELL_MAX,  CELL_MAX,  0,     0,  0,     0, 0, pgd_pkg::STAT_OK);
      add_row(32768,     CELL_MAX,  1,         1,         0,     0,  0,     0, 0, pgd_pkg::STAT_OK);
      add_row(12,        0,         CELL_MAX,  0,         0,     0,  0,     0, 0, pgd_pkg::STAT_OK);
      add_row(100,       10,        10,        1,         0,     0,  0,     0, 0, pgd_pkg::STAT_OK);
      add_row(4,         5,         5,         5,         0,     0,  0,     0, 0, pgd_pkg::STAT_OK);
      add_row(60,        3,         20,        4,         0,     0,  0,     0, 0, pgd_pkg::STAT_OK);
      add_row(36,        6,         6,         6,         0,     0,  0,     0, 0, pgd_pkg::STAT_OK);
      add_row(16'hAAAA,  20'hAAAAA, 20'h55555, CELL_MAX,  0,     0,  0,     0, 0, pgd_pkg::STAT_OK);
      add_row(16'h5555,  20'h55555, 20'hAAAAA, 0,         0,     0,  0,     0, 0, pgd_pkg::STAT_OK);

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      foreach (dims_rows[i])
         send_item(dims_rows[i].ranks, dims_rows[i].cx, dims_rows[i].cy, dims_rows[i].cz,
                   dims_rows[i].typed, dims_rows[i].want);

      repeat (RANDOM_ITEMS) begin
         m = $urandom_range(0, 99);
         cx = draw_cells();
         cy = draw_cells();
         cz = draw_cells();
         if (m < 55) begin
            ranks = RANK_BITS'($urandom_range(1, 1023));
         end else if (m < 70) begin
            // large counts, often with a big prime left over
            ranks = RANK_BITS'($urandom_range(0, 2**RANK_BITS - 1));
         end else if (m < 85) begin
            smooth = 1;
            repeat ($urandom_range(1, 14)) begin
               case ($urandom_range(0, 3))
                  0: f = 2;
                  1: f = 3;
                  2: f = 5;
                  default: f = 7;
               endcase
               if (smooth * f <= int'(RANK_MAX)) smooth = smooth * f;
            end
            ranks = smooth[RANK_BITS-1:0];
         end else begin
            // small grids, mostly too many ranks
            ranks = RANK_BITS'($urandom_range(0, 2**RANK_BITS - 1));
            cx = CELL_BITS'($urandom_range(0, 8));
            cy = CELL_BITS'($urandom_range(0, 8));
            cz = CELL_BITS'($urandom_range(0, 8));
         end
         send_item(ranks, cx, cy, cz, 1'b0, none);
      end

      start <= 1'b0;
      while (pending_choices.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

// ----- files.f -----
sv/pgd_pkg.sv
sv/process_grid_dims_top.sv
test/process_grid_dims_top_tb.sv
